FILE: rtl/assert_macros.svh
// shared assertion macros for the ranging block checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, quiet during reset
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// implication into the next cycle, quiet during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/dstwr_pkg.sv
package dstwr_pkg;

  localparam int TS_BYTES_DEF = 4;
  localparam int TS_W         = 32;
  localparam int LOC_W        = 40;
  localparam int PROD_W       = 64;
  localparam int SUM_W        = 34;
  localparam int QUOT_W       = 32;
  localparam int OUT_W        = 64;

endpackage

FILE: rtl/dstwr_div.sv
module dstwr_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [dstwr_pkg::PROD_W-1:0]    in_mag,
  input  logic [dstwr_pkg::SUM_W-1:0]     in_sum,
  input  logic                            in_neg,
  input  logic                            in_zero,
  output logic                            out_vld,
  output logic [dstwr_pkg::QUOT_W-1:0]    out_quot,
  output logic                            out_neg,
  output logic                            out_zero
);

  localparam int N  = dstwr_pkg::QUOT_W;
  localparam int SW = dstwr_pkg::SUM_W;

  logic          vld_r  [N];
  logic [SW-1:0] rem_r  [N];
  logic [N-1:0]  w_r    [N];
  logic [SW-1:0] sum_r  [N];
  logic          neg_r  [N];
  logic          zero_r [N];

  logic          src_vld  [N];
  logic [SW-1:0] src_rem  [N];
  logic [N-1:0]  src_w    [N];
  logic [SW-1:0] src_sum  [N];
  logic          src_neg  [N];
  logic          src_zero [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_step
      logic [SW:0]   trial;
      logic          take;
      logic [SW-1:0] rem_nxt;

      if (i == 0) begin : g_first
        // high half of the dividend is known to be below the divisor
        assign src_vld[i]  = in_vld;
        assign src_rem[i]  = {{(SW-N){1'b0}}, in_mag[dstwr_pkg::PROD_W-1:N]};
        assign src_w[i]    = in_mag[N-1:0];
        assign src_sum[i]  = in_sum;
        assign src_neg[i]  = in_neg;
        assign src_zero[i] = in_zero;
      end else begin : g_rest
        assign src_vld[i]  = vld_r[i-1];
        assign src_rem[i]  = rem_r[i-1];
        assign src_w[i]    = w_r[i-1];
        assign src_sum[i]  = sum_r[i-1];
        assign src_neg[i]  = neg_r[i-1];
        assign src_zero[i] = zero_r[i-1];
      end

      assign trial   = {src_rem[i], src_w[i][N-1]};
      assign take    = (trial >= {1'b0, src_sum[i]});
      assign rem_nxt = take ? SW'(trial - {1'b0, src_sum[i]}) : trial[SW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= src_vld[i];
        end
      end

      // dividend bits shift out the top while quotient bits enter below
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i]  <= rem_nxt;
          w_r[i]    <= {src_w[i][N-2:0], take};
          sum_r[i]  <= src_sum[i];
          neg_r[i]  <= src_neg[i];
          zero_r[i] <= src_zero[i];
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[N-1];
  assign out_quot = w_r[N-1];
  assign out_neg  = neg_r[N-1];
  assign out_zero = zero_r[N-1];

endmodule

FILE: rtl/ds_twr_time_of_flight.sv
// throughput: one ranging set per cycle; the whole pipeline holds while a result is stalled
// division is one quotient bit per stage over 32 stages, after diff, multiply and subtract
// reset: synchronous active-low rst_n clears all valid bits; data registers are not reset
module ds_twr_time_of_flight #(
  parameter int TS_BYTES = dstwr_pkg::TS_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dstwr_pkg::TS_W-1:0]    in_remote_poll_sent,
  input  logic [dstwr_pkg::TS_W-1:0]    in_remote_reply_got,
  input  logic [dstwr_pkg::TS_W-1:0]    in_remote_final_sent,
  input  logic [dstwr_pkg::LOC_W-1:0]   in_local_poll_got,
  input  logic [dstwr_pkg::LOC_W-1:0]   in_local_reply_sent,
  input  logic [dstwr_pkg::LOC_W-1:0]   in_local_final_got,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dstwr_pkg::OUT_W-1:0] out_flight_time,
  output logic                          out_zero_divisor
);

  localparam int TW  = dstwr_pkg::TS_W;
  localparam int PW  = dstwr_pkg::PROD_W;
  localparam int SW  = dstwr_pkg::SUM_W;
  localparam int QW  = dstwr_pkg::QUOT_W;
  localparam int OW  = dstwr_pkg::OUT_W;
  // remote timestamps carry at most TS_BYTES bytes, capped at 32 bits
  localparam int RW  = (TS_BYTES * 8 >= TW) ? TW : TS_BYTES * 8;
  localparam logic [TW-1:0] RMASK = TW'((65'd1 << RW) - 65'd1);

  // one enable for every stage: advance unless the result slot is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: wrapping interval differences
  logic          s1_vld_r;
  logic [TW-1:0] ra_r, da_r, db_r, rb_r;
  logic [TW-1:0] r_poll, r_reply, r_final;

  assign r_poll  = in_remote_poll_sent  & RMASK;
  assign r_reply = in_remote_reply_got  & RMASK;
  assign r_final = in_remote_final_sent & RMASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r <= r_reply - r_poll;
      da_r <= r_final - r_reply;
      db_r <= in_local_reply_sent[TW-1:0] - in_local_poll_got[TW-1:0];
      rb_r <= in_local_final_got[TW-1:0]  - in_local_reply_sent[TW-1:0];
    end
  end

  // stage 2: the two products and the interval sum
  logic          s2_vld_r;
  logic [PW-1:0] p_r, q_r;
  logic [SW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= PW'(ra_r) * PW'(rb_r);
      q_r   <= PW'(da_r) * PW'(db_r);
      sum_r <= SW'(ra_r) + SW'(rb_r) + SW'(da_r) + SW'(db_r);
    end
  end

  // stage 3: magnitude and sign of the product difference
  logic          s3_vld_r;
  logic [PW-1:0] mag_r;
  logic [SW-1:0] sum3_r;
  logic          neg_r, zero_r;
  logic          p_lt_q;

  assign p_lt_q = (p_r < q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= p_lt_q ? (q_r - p_r) : (p_r - q_r);
      neg_r  <= p_lt_q;
      zero_r <= (sum_r == '0);
      sum3_r <= sum_r;
    end
  end

  // stages 4..35: restoring divider, one quotient bit per stage
  logic          dv_vld, dv_neg, dv_zero;
  logic [QW-1:0] dv_quot;

  dstwr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_mag   (mag_r),
    .in_sum   (sum3_r),
    .in_neg   (neg_r),
    .in_zero  (zero_r),
    .out_vld  (dv_vld),
    .out_quot (dv_quot),
    .out_neg  (dv_neg),
    .out_zero (dv_zero)
  );

  // stage 36: sign, zero divisor override, output register
  logic          out_vld_r;
  logic [OW-1:0] flight_r;
  logic          zdiv_r;
  logic [OW-1:0] quot_ext;

  assign quot_ext = OW'(dv_quot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flight_r <= dv_zero ? '0 : (dv_neg ? (OW'(0) - quot_ext) : quot_ext);
      zdiv_r   <= dv_zero;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flight_time  = signed'(flight_r);
  assign out_zero_divisor = zdiv_r;

endmodule

FILE: rtl/dstwr_chk.sv
`include "assert_macros.svh"

module dstwr_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [dstwr_pkg::OUT_W-1:0] out_flight_time,
  input logic                               out_zero_divisor
);

  // a held result stays put
  `CHK_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_flight_time))

  // zero divisor always comes with a zero time of flight
  `CHK_SAME(a_zero, out_valid && out_zero_divisor, out_flight_time == '0)

  // input only stalls while a result is held downstream
  `CHK_SAME(a_stall, in_stall, out_valid && out_stall)

  // nothing comes out right after reset
  `CHK_SAME(a_rst, $past(!rst_n), !out_valid)

endmodule

bind ds_twr_time_of_flight dstwr_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_flight_time  (out_flight_time),
  .out_zero_divisor (out_zero_divisor)
);

FILE: bench/ds_twr_time_of_flight_test.sv
module ds_twr_time_of_flight_test;

  // one ranging set as offered on the input channel
  typedef struct packed {
    logic [dstwr_pkg::TS_W-1:0]  r_poll;
    logic [dstwr_pkg::TS_W-1:0]  r_reply;
    logic [dstwr_pkg::TS_W-1:0]  r_final;
    logic [dstwr_pkg::LOC_W-1:0] l_poll;
    logic [dstwr_pkg::LOC_W-1:0] l_reply;
    logic [dstwr_pkg::LOC_W-1:0] l_final;
  } ranging_set_t;

  // expected time of flight for one set
  typedef struct packed {
    logic [dstwr_pkg::OUT_W-1:0] tof;
    logic                        zdiv;
  } tof_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [dstwr_pkg::TS_W-1:0]  in_remote_poll_sent = '0;
  logic [dstwr_pkg::TS_W-1:0]  in_remote_reply_got = '0;
  logic [dstwr_pkg::TS_W-1:0]  in_remote_final_sent = '0;
  logic [dstwr_pkg::LOC_W-1:0] in_local_poll_got = '0;
  logic [dstwr_pkg::LOC_W-1:0] in_local_reply_sent = '0;
  logic [dstwr_pkg::LOC_W-1:0] in_local_final_got = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [dstwr_pkg::OUT_W-1:0] out_flight_time;
  logic out_zero_divisor;

  ranging_set_t pending_sets[$];
  tof_result_t  expected_tofs[$];
  int errors = 0;
  int sets_sent = 0;
  int results_seen = 0;
  int zero_div_seen = 0;
  int neg_seen = 0;
  bit stimulus_done = 1'b0;

  ds_twr_time_of_flight dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // time of flight from the six timestamps, exact integer math
  function automatic tof_result_t predict_tof(ranging_set_t s);
    logic [31:0] ra, da, db, rb;
    logic [63:0] p, q, mag, quot;
    logic [63:0] sum;
    tof_result_t r;
    ra = s.r_reply - s.r_poll;
    da = s.r_final - s.r_reply;
    db = s.l_reply[31:0] - s.l_poll[31:0];
    rb = s.l_final[31:0] - s.l_reply[31:0];
    p = 64'(ra) * 64'(rb);
    q = 64'(da) * 64'(db);
    sum = 64'(ra) + 64'(rb) + 64'(da) + 64'(db);
    if (sum == 0) begin
      r.tof = '0;
      r.zdiv = 1'b1;
    end else begin
      mag = (p >= q) ? p - q : q - p;
      quot = mag / sum;
      r.tof = (p >= q) ? quot : 64'd0 - quot;
      r.zdiv = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [dstwr_pkg::LOC_W-1:0] rand_loc();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // plausible exchange: small intervals from a random base, random high bytes
  function automatic ranging_set_t rand_exchange();
    ranging_set_t s;
    logic [31:0] rb0, lb0;
    logic [31:0] ra, da, db, rb, tof;
    int lim;
    lim = ($urandom_range(0, 9) == 0) ? 32'h7fff_ffff : 32'h000f_ffff;
    tof = $urandom_range(0, 2000);
    db = $urandom_range(0, lim);
    da = $urandom_range(0, lim);
    ra = 2 * tof + db + $urandom_range(0, 50) - 25;
    rb = 2 * tof + da + $urandom_range(0, 50) - 25;
    rb0 = $urandom;
    lb0 = $urandom;
    s.r_poll = rb0;
    s.r_reply = rb0 + ra;
    s.r_final = rb0 + ra + da;
    s.l_poll = {8'($urandom), lb0};
    s.l_reply = {8'($urandom), lb0 + db};
    s.l_final = {8'($urandom), lb0 + db + rb};
    return s;
  endfunction

  function automatic ranging_set_t rand_noise();
    ranging_set_t s;
    s.r_poll = $urandom;
    s.r_reply = $urandom;
    s.r_final = $urandom;
    s.l_poll = rand_loc();
    s.l_reply = rand_loc();
    s.l_final = rand_loc();
    return s;
  endfunction

  // directed sets, then random ones; the driver drains the queue
  initial begin
    ranging_set_t s;
    // all zero: zero divisor
    s = '0;
    pending_sets.push_back(s);
    // equal timestamps with high local bits set: still zero divisor
    s.r_poll = 32'hffff_ffff; s.r_reply = 32'hffff_ffff; s.r_final = 32'hffff_ffff;
    s.l_poll = '1; s.l_reply = '1; s.l_final = '1;
    pending_sets.push_back(s);
    // intervals summing to 2^32 wrap: sum is nonzero in wide math
    s = '0;
    s.r_reply = 32'h8000_0000; s.r_final = 32'h0;
    pending_sets.push_back(s);
    // max intervals everywhere
    s = '0;
    s.r_reply = 32'hffff_ffff; s.r_final = 32'hffff_fffe;
    s.l_reply = 40'hff_ffff_ffff; s.l_final = 40'h00_ffff_fffe;
    pending_sets.push_back(s);
    // only Ra and Rb large: largest positive quotient
    s = '0;
    s.r_reply = 32'hffff_ffff; s.r_final = 32'hffff_ffff;
    s.l_final = 40'hff_ffff_ffff;
    pending_sets.push_back(s);
    // only Da and Db large: largest negative quotient
    s = '0;
    s.r_final = 32'hffff_ffff;
    s.l_reply = 40'h00_ffff_ffff; s.l_final = 40'h00_ffff_ffff;
    pending_sets.push_back(s);
    // single unit intervals
    s = '0;
    s.r_reply = 1; s.r_final = 2; s.l_reply = 1; s.l_final = 2;
    pending_sets.push_back(s);
    // negative quotient: Da*Db exceeds Ra*Rb
    s = '0;
    s.r_reply = 1; s.r_final = 4; s.l_reply = 3; s.l_final = 4;
    pending_sets.push_back(s);
    // high local bits differ but low 32 equal
    s = '0;
    s.l_poll = 40'h12_0000_0000; s.l_reply = 40'h34_0000_0000; s.l_final = 40'hab_0000_0000;
    pending_sets.push_back(s);
    // alternating bit patterns
    s.r_poll = 32'haaaa_aaaa; s.r_reply = 32'h5555_5555; s.r_final = 32'haaaa_aaaa;
    s.l_poll = 40'h55_5555_5555; s.l_reply = 40'haa_aaaa_aaaa; s.l_final = 40'h55_5555_5555;
    pending_sets.push_back(s);
    for (int i = 0; i < 6; i++) pending_sets.push_back(rand_exchange());
    for (int i = 0; i < 1340; i++)
      pending_sets.push_back(($urandom_range(0, 3) == 0) ? rand_noise() : rand_exchange());
  end

  // accept flag from the last rising edge
  logic taken_q = 1'b0;

  // driver: bursts and gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    ranging_set_t s;
    if (rst_n) begin
      if (!in_valid || taken_q) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_sets.size() > 0) begin
          s = pending_sets.pop_front();
          in_remote_poll_sent <= s.r_poll;
          in_remote_reply_got <= s.r_reply;
          in_remote_final_sent <= s.r_final;
          in_local_poll_got <= s.l_poll;
          in_local_reply_sent <= s.l_reply;
          in_local_final_got <= s.l_final;
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
          stimulus_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    taken_q <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_tofs.push_back(predict_tof({in_remote_poll_sent, in_remote_reply_got,
        in_remote_final_sent, in_local_poll_got, in_local_reply_sent, in_local_final_got}));
      sets_sent <= sets_sent + 1;
    end
  end

  // receiver stall pattern, with one long hold-off to back the pipeline up
  int stall_phase = 0;
  int hold_count = 0;
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b1;
    else if (sets_sent > 300 && hold_count < 200) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 1;
      if ((stall_phase / 64) % 3 == 0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin
    tof_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tofs.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        exp_r = expected_tofs.pop_front();
        results_seen++;
        if (exp_r.zdiv) zero_div_seen++;
        if (exp_r.tof[dstwr_pkg::OUT_W-1]) neg_seen++;
        if (out_flight_time !== exp_r.tof) begin
          $error("flight_time expected %0d got %0d", $signed(exp_r.tof), out_flight_time);
          errors++;
        end
        if (out_zero_divisor !== exp_r.zdiv) begin
          $error("zero_divisor expected %0b got %0b", exp_r.zdiv, out_zero_divisor);
          errors++;
        end
      end
    end
  end

  // reset, then wait for the queues to drain
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_tofs.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_tofs.size() != 0) begin
      $error("%0d results never arrived", expected_tofs.size());
      errors++;
    end
    $display("covered %0d ranging sets, %0d results checked", sets_sent, results_seen);
    $display("zero divisor cases %0d, negative flight times %0d", zero_div_seen, neg_seen);
    if (errors == 0) $display("ds_twr_time_of_flight_test passed");
    else $display("ds_twr_time_of_flight_test failed");
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("ds_twr_time_of_flight_test failed");
    $finish;
  end

endmodule
